@@ sv/tcw_pkg.sv @@
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int unsigned ADDR_W = 14;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [ADDR_W-1:0] ADDR_MAX = 14'h3FFF;

  localparam logic [CMD_W-1:0] CMD_CHAR        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCROLL_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ATTR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT_ATTR = 3'd4;

  // one recorded newline jump
  typedef struct packed {
    logic [ADDR_W-1:0] from;
    logic [7:0]        len;
  } jump_entry_t;

endpackage

@@ sv/tcw_stack.sv @@
`timescale 1ns / 1ps
module tcw_stack #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  tcw_pkg::jump_entry_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output tcw_pkg::jump_entry_t rd_data_o
);

  tcw_pkg::jump_entry_t mem [DEPTH];
  tcw_pkg::jump_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/tcw_colrem.sv @@
`timescale 1ns / 1ps
// Column of an offset within a row: offset mod COLS by a scaled reciprocal.
// The product is registered; the remainder is combinational from it and valid in the cycle after load.
module tcw_colrem #(
  parameter int unsigned COLS = 80
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [tcw_pkg::ADDR_W-1:0] offs_i,
  output logic [7:0]                 rem_o
);

  localparam int unsigned SHIFT  = tcw_pkg::ADDR_W + 8;
  localparam int unsigned RCP_W  = SHIFT - 2;
  localparam int unsigned PROD_W = tcw_pkg::ADDR_W + RCP_W;
  localparam int unsigned QUO_W  = PROD_W - SHIFT;
  localparam int unsigned MUL_W  = QUO_W + 8;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHIFT) / COLS);
  localparam logic [7:0]       COLS_B = 8'(COLS);

  logic [PROD_W-1:0]          prod_q;
  logic [tcw_pkg::ADDR_W-1:0] offs_q;
  logic [QUO_W-1:0]           quo_est;
  logic [MUL_W-1:0]           back_mul;
  logic [MUL_W-1:0]           rem_wide;
  logic [8:0]                 rem_raw;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PROD_W'(offs_i) * PROD_W'(RECIP);
      offs_q <= offs_i;
    end
  end

  // the estimate is low by at most one, so one corrective subtract suffices
  assign quo_est  = prod_q[PROD_W-1:SHIFT];
  assign back_mul = MUL_W'(quo_est) * MUL_W'(COLS_B);
  assign rem_wide = MUL_W'(offs_q) - back_mul;
  assign rem_raw  = rem_wide[8:0];
  assign rem_o    = (rem_raw >= {1'b0, COLS_B}) ? 8'(rem_raw - {1'b0, COLS_B})
                                                : rem_raw[7:0];

endmodule

@@ sv/text_console_writer_unit.sv @@
`timescale 1ns / 1ps
// A request goes from the input holding register through the execute and follow
// steps to the output register; the follow step scrolls the view down a row at a
// time to track the cursor. The input register takes the next request meanwhile.
// Reset: cursor, view start, jump count and registers return to defaults; stack
// contents are left as they are and only entries below the jump count are used.
module text_console_writer_unit #(
  parameter int unsigned SCREEN_COLS  = 80,
  parameter int unsigned SCREEN_CELLS = 2000,
  parameter int unsigned JUMP_DEPTH   = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // char_code
  input  logic [1:0]                     s_axis_tuser,  // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cell_addr, cell_char, cell_attr, cursor_pos, view_start, zero pad
  output logic [63:0]                    m_axis_tdata,
  output logic [0:0]                     m_axis_tuser,  // cell_write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(JUMP_DEPTH);
  localparam int unsigned CNT_W = $clog2(JUMP_DEPTH + 1);
  localparam int unsigned AW    = tcw_pkg::ADDR_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_FOLLOW = 2'd2;

  localparam logic [15:0] COLS16  = 16'(SCREEN_COLS);
  localparam logic [15:0] CELLS16 = 16'(SCREEN_CELLS);
  localparam logic [15:0] AMAX16  = {2'b00, tcw_pkg::ADDR_MAX};
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(JUMP_DEPTH);

  // configuration
  logic [AW-1:0]                 base_q;
  logic [tcw_pkg::SIZE_W-1:0]    size_q;
  logic                          hl_mode_q;
  logic [7:0]                    norm_attr_q, hl_attr_q;

  // input holding register
  logic                          in_full_q;
  logic [1:0]                    in_cmd_q;
  logic [7:0]                    in_char_q;

  // engine
  logic [1:0]                    state_q, state_d;
  logic [1:0]                    cmd_q;
  logic [7:0]                    char_q;
  logic [AW-1:0]                 cursor_q, cursor_d;
  logic [AW-1:0]                 start_q, start_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          wr_q, wr_d;
  logic [AW-1:0]                 waddr_q, waddr_d;
  logic [7:0]                    wchar_q, wchar_d;
  logic [7:0]                    wattr_q, wattr_d;

  // output register
  logic                          out_valid_q;
  logic                          out_wr_q;
  logic [AW-1:0]                 out_addr_q, out_cursor_q, out_view_q;
  logic [7:0]                    out_char_q, out_attr_q;

  logic                          start_item, out_free, out_load, follow_scroll, can_down;
  logic                          push;
  logic [CNT_W-1:0]              cnt_m1;
  tcw_pkg::jump_entry_t          push_entry, top_entry;
  logic [7:0]                    col_rem;
  logic [8:0]                    jump_step;
  logic [15:0]                   end16, cur16, start16, base16, target16, top_end16;

  tcw_stack #(.DEPTH(JUMP_DEPTH)) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (push),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (push_entry),
    .rd_en_i   (start_item),
    .rd_addr_i (cnt_m1[IDX_W-1:0]),
    .rd_data_o (top_entry)
  );

  tcw_colrem #(.COLS(SCREEN_COLS)) u_colrem (
    .clk_i  (clk_i),
    .load_i (start_item),
    .offs_i (cursor_q - base_q),
    .rem_o  (col_rem)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !in_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      size_q      <= 15'd16384;
      hl_mode_q   <= 1'b0;
      norm_attr_q <= 8'd7;
      hl_attr_q   <= 8'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tcw_pkg::REG_REGION_BASE:    base_q      <= cfg_data_i[AW-1:0];
        tcw_pkg::REG_REGION_SIZE:    size_q      <= cfg_data_i;
        tcw_pkg::REG_HIGHLIGHT_MODE: hl_mode_q   <= cfg_data_i[0];
        tcw_pkg::REG_NORMAL_ATTR:    norm_attr_q <= cfg_data_i[7:0];
        tcw_pkg::REG_HIGHLIGHT_ATTR: hl_attr_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign end16     = {2'b00, base_q} + {1'b0, size_q};
  assign cur16     = {2'b00, cursor_q};
  assign start16   = {2'b00, start_q};
  assign base16    = {2'b00, base_q};
  assign jump_step = 9'(SCREEN_COLS) - {1'b0, col_rem};
  assign target16  = cur16 + {7'b0, jump_step};
  assign top_end16 = {2'b00, top_entry.from} + {8'b0, top_entry.len};
  assign cnt_m1    = count_q - CNT_W'(1);

  assign can_down      = (start16 + CELLS16 < end16) && (start16 + COLS16 <= AMAX16);
  assign follow_scroll = (cmd_q == tcw_pkg::CMD_CHAR) && (cur16 >= start16 + CELLS16)
                         && can_down;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign start_item    = in_full_q && ((state_q == ST_IDLE) ||
                         ((state_q == ST_FOLLOW) && !follow_scroll && out_free));

  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    start_d    = start_q;
    count_d    = count_q;
    wr_d       = wr_q;
    waddr_d    = waddr_q;
    wchar_d    = wchar_q;
    wattr_d    = wattr_q;
    push       = 1'b0;
    push_entry = '{from: cursor_q, len: jump_step[7:0]};
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_item) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        wr_d    = 1'b0;
        waddr_d = '0;
        wchar_d = '0;
        wattr_d = '0;
        state_d = ST_FOLLOW;
        case (cmd_q)
          tcw_pkg::CMD_SCROLL_UP: begin
            if (start_q > base_q) begin
              if (start16 >= base16 + COLS16) start_d = start_q - AW'(SCREEN_COLS);
              else                           start_d = base_q;
            end
          end
          tcw_pkg::CMD_SCROLL_DOWN: begin
            if (can_down) start_d = start_q + AW'(SCREEN_COLS);
          end
          tcw_pkg::CMD_CHAR: begin
            if (char_q == tcw_pkg::CH_NEWLINE) begin
              if (cursor_q < base_q) begin
                cursor_d = base_q;
              end else if ((cur16 + COLS16 < end16) && (target16 <= AMAX16)) begin
                if (count_q != FULL_CNT) begin
                  push    = 1'b1;
                  count_d = count_q + CNT_W'(1);
                end
                cursor_d = target16[AW-1:0];
              end
            end else if (char_q == tcw_pkg::CH_BACKSPACE) begin
              if (cursor_q > base_q) begin
                if ((count_q != '0) && (cur16 == top_end16)) begin
                  // cursor sits at the end of the last newline: undo the jump
                  cursor_d = cursor_q - AW'(top_entry.len);
                  count_d  = cnt_m1;
                end else begin
                  cursor_d = cursor_q - AW'(1);
                  wr_d     = 1'b1;
                  waddr_d  = cursor_q - AW'(1);
                  wchar_d  = tcw_pkg::CH_BLANK;
                  wattr_d  = norm_attr_q;
                end
              end
            end else begin
              if ((cur16 + 16'd1 < end16) && (cursor_q < tcw_pkg::ADDR_MAX)) begin
                wr_d     = 1'b1;
                waddr_d  = cursor_q;
                wchar_d  = char_q;
                wattr_d  = hl_mode_q ? hl_attr_q : norm_attr_q;
                cursor_d = cursor_q + AW'(1);
              end
            end
          end
          default: ;
        endcase
      end
      ST_FOLLOW: begin
        if (follow_scroll) begin
          start_d = start_q + AW'(SCREEN_COLS);
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = start_item ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      start_q     <= '0;
      count_q     <= '0;
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      start_q  <= start_d;
      count_q  <= count_d;
      if (s_axis_tvalid && s_axis_tready) in_full_q <= 1'b1;
      else if (start_item)                in_full_q <= 1'b0;
      if (out_load)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
    if (start_item) begin
      cmd_q  <= in_cmd_q;
      char_q <= in_char_q;
    end
    wr_q    <= wr_d;
    waddr_q <= waddr_d;
    wchar_q <= wchar_d;
    wattr_q <= wattr_d;
    if (out_load) begin
      out_wr_q     <= wr_q;
      out_addr_q   <= waddr_q;
      out_char_q   <= wchar_q;
      out_attr_q   <= wattr_q;
      out_cursor_q <= cursor_q;
      out_view_q   <= start_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_wr_q;
  assign m_axis_tdata  = {6'b0, out_view_q, out_cursor_q, out_attr_q, out_char_q,
                          out_addr_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("jump count above stack depth");

  a_exec_to_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> (state_q == ST_FOLLOW))
    else $error("execute step not followed by follow step");

  a_load_from_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> ((state_q == ST_FOLLOW) && !follow_scroll))
    else $error("result issued while the view still follows");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[29:0] == 30'd0))
    else $error("cell fields not cleared without a write");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned SCREEN_COLS  = 80;
  localparam int unsigned SCREEN_CELLS = 2000;
  localparam int unsigned JUMP_DEPTH   = 1024;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CHUNK_ITEMS  = 22;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam int unsigned AW           = tcw_pkg::ADDR_W;

  // cmd value with no meaning: the block must leave its state alone
  localparam logic [tcw_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::CMD_W-1:0]  cmd;
    logic [tcw_pkg::CHAR_W-1:0] ch;
  } console_req_t;

  typedef struct packed {
    logic                       wr;
    logic [tcw_pkg::ADDR_W-1:0] addr;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::ATTR_W-1:0] attr;
    logic [tcw_pkg::ADDR_W-1:0] cursor;
    logic [tcw_pkg::ADDR_W-1:0] view;
  } cell_update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;
  logic [1:0]                     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [63:0]                    m_axis_tdata;
  logic [0:0]                     m_axis_tuser;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  text_console_writer_unit #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_CELLS(SCREEN_CELLS),
    .JUMP_DEPTH  (JUMP_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // console state as the block should hold it
  int unsigned con_cursor = 0;
  int unsigned con_view = 0;
  int unsigned jump_used = 0;
  logic [tcw_pkg::ADDR_W-1:0] jump_from_mem [JUMP_DEPTH];
  logic [7:0]                 jump_len_mem  [JUMP_DEPTH];

  int unsigned reg_base = 0;
  int unsigned reg_size = 16384;
  int unsigned reg_hl_mode = 0;
  int unsigned reg_norm_attr = 7;
  int unsigned reg_hl_attr = 1;

  console_req_t pending_reqs[$];
  cell_update_t pending_cell_updates[$];
  int unsigned  sent_total = 0;
  int unsigned  accepted_total = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  int unsigned  hold_requests = 0;
  int unsigned  hold_served = 0;
  int unsigned  hold_left = 0;

  console_req_t drv_req;
  int unsigned  send_gap = 0;
  bit           send_calm = 1'b0;
  int unsigned  recv_gap = 0;
  bit           recv_calm = 1'b0;

  function automatic bit view_down();
    if (con_view + SCREEN_CELLS < reg_base + reg_size &&
        con_view + SCREEN_COLS <= tcw_pkg::ADDR_MAX) begin
      con_view = con_view + SCREEN_COLS;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void view_up();
    if (con_view > reg_base) begin
      if (con_view >= reg_base + SCREEN_COLS) con_view = con_view - SCREEN_COLS;
      else con_view = reg_base;
    end
  endfunction

  function automatic void apply_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                    input int unsigned value);
    case (idx)
      tcw_pkg::REG_REGION_BASE:    reg_base = value & tcw_pkg::ADDR_MAX;
      tcw_pkg::REG_REGION_SIZE:    reg_size = value & 32'h7FFF;
      tcw_pkg::REG_HIGHLIGHT_MODE: reg_hl_mode = value & 32'h1;
      tcw_pkg::REG_NORMAL_ATTR:    reg_norm_attr = value & 32'hFF;
      tcw_pkg::REG_HIGHLIGHT_ATTR: reg_hl_attr = value & 32'hFF;
      default: ;
    endcase
  endfunction

  function automatic cell_update_t console_step(input logic [tcw_pkg::CMD_W-1:0] cmd,
                                                input logic [tcw_pkg::CHAR_W-1:0] ch);
    cell_update_t r;
    int unsigned  row;
    int unsigned  target;
    int unsigned  top;
    r = '0;
    case (cmd)
      tcw_pkg::CMD_SCROLL_UP:   view_up();
      tcw_pkg::CMD_SCROLL_DOWN: void'(view_down());
      tcw_pkg::CMD_CHAR: begin
        if (ch == tcw_pkg::CH_NEWLINE) begin
          if (con_cursor < reg_base) begin
            con_cursor = reg_base;
          end else if (con_cursor + SCREEN_COLS < reg_base + reg_size) begin
            row = (con_cursor - reg_base) / SCREEN_COLS;
            target = reg_base + SCREEN_COLS * (row + 1);
            if (target <= tcw_pkg::ADDR_MAX) begin
              // a full stack drops the jump but still moves the cursor
              if (jump_used < JUMP_DEPTH) begin
                jump_from_mem[jump_used] = AW'(con_cursor);
                jump_len_mem[jump_used] = 8'(target - con_cursor);
                jump_used++;
              end
              con_cursor = target;
            end
          end
        end else if (ch == tcw_pkg::CH_BACKSPACE) begin
          if (con_cursor > reg_base) begin
            top = jump_used - 1;
            if (jump_used > 0 && con_cursor == jump_from_mem[top] + jump_len_mem[top]) begin
              con_cursor = con_cursor - jump_len_mem[top];
              jump_used--;
            end else begin
              con_cursor--;
              r.wr = 1'b1;
              r.addr = AW'(con_cursor);
              r.ch = tcw_pkg::CH_BLANK;
              r.attr = 8'(reg_norm_attr);
            end
          end
        end else if (con_cursor + 1 < reg_base + reg_size &&
                     con_cursor < tcw_pkg::ADDR_MAX) begin
          r.wr = 1'b1;
          r.addr = AW'(con_cursor);
          r.ch = ch;
          r.attr = reg_hl_mode != 0 ? 8'(reg_hl_attr) : 8'(reg_norm_attr);
          con_cursor++;
        end
        // follow the cursor down while the view can still move
        while (con_cursor >= con_view + SCREEN_CELLS) begin
          if (!view_down()) break;
        end
      end
      default: ;
    endcase
    r.cursor = AW'(con_cursor);
    r.view = AW'(con_view);
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_result();
    cell_update_t want;
    if (pending_cell_updates.size() == 0) begin
      note_mismatch($sformatf("unexpected result tuser %b tdata %h", m_axis_tuser, m_axis_tdata));
      return;
    end
    want = pending_cell_updates.pop_front();
    check_field("cell_write", m_axis_tuser[0], want.wr);
    check_field("cell_addr", m_axis_tdata[13:0], want.addr);
    check_field("cell_char", m_axis_tdata[21:14], want.ch);
    check_field("cell_attr", m_axis_tdata[29:22], want.attr);
    check_field("cursor_pos", m_axis_tdata[43:30], want.cursor);
    check_field("view_start", m_axis_tdata[57:44], want.view);
  endtask

  // sender: offer queued requests, predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_cell_updates.push_back(console_step(drv_req.cmd, drv_req.ch));
        accepted_total++;
        send_gap = send_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          drv_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= drv_req.ch;
          s_axis_tuser <= drv_req.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls per result, plus the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        recv_gap = recv_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      end else if (m_axis_tvalid && recv_gap != 0) begin
        recv_gap--;
      end
      m_axis_tready <= (hold_left == 0) && (recv_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_req(input logic [tcw_pkg::CMD_W-1:0] cmd,
                           input logic [tcw_pkg::CHAR_W-1:0] ch);
    console_req_t req;
    req.cmd = cmd;
    req.ch = ch;
    pending_reqs.push_back(req);
    sent_total++;
  endtask

  task automatic wait_drained();
    while (accepted_total != sent_total || pending_cell_updates.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[tcw_pkg::CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic queue_typing();
    int unsigned pick;
    int unsigned depth;
    pick = $urandom_range(0, 99);
    if (pick < 45) queue_req(tcw_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
    else if (pick < 55) queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    else if (pick < 82) queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    else if (pick < 86) queue_req(tcw_pkg::CMD_SCROLL_UP, 8'($urandom_range(0, 255)));
    else if (pick < 90) queue_req(tcw_pkg::CMD_SCROLL_DOWN, 8'($urandom_range(0, 255)));
    else if (pick < 92) queue_req(CMD_NONE, 8'($urandom_range(0, 255)));
    else begin
      // nested line breaks, then undo them one by one
      depth = $urandom_range(1, 4);
      repeat (depth) queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
      repeat (depth) queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    end
  endtask

  initial begin
    int unsigned chunk_start;
    int unsigned new_base;
    int unsigned new_size;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the jump stack: the first newline drops the cursor a row, then slide the
    // region base so that the cursor sits in the last column and every newline is a
    // one-cell jump
    repeat (JUMP_DEPTH + 6) begin
      wait_drained();
      write_reg(tcw_pkg::REG_REGION_BASE,
                con_cursor >= SCREEN_COLS - 1 ? con_cursor - (SCREEN_COLS - 1) : 0);
      queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    end
    write_reg(tcw_pkg::REG_REGION_BASE, 0);
    // unwind: blank past the unrecorded jumps, then pop a few recorded ones
    repeat (16) queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);

    wait_drained();
    write_reg(tcw_pkg::REG_REGION_BASE, con_cursor + 40);
    write_reg(tcw_pkg::REG_REGION_SIZE, 400);
    write_reg(tcw_pkg::REG_NORMAL_ATTR, 8'h00);
    write_reg(tcw_pkg::REG_HIGHLIGHT_ATTR, 8'hFF);
    queue_req(tcw_pkg::CMD_CHAR, 8'hFF);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    queue_req(tcw_pkg::CMD_CHAR, 8'h00);
    queue_req(tcw_pkg::CMD_CHAR, "n");
    queue_req(tcw_pkg::CMD_CHAR, "l");
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    queue_req(tcw_pkg::CMD_SCROLL_UP, 8'h00);
    queue_req(tcw_pkg::CMD_SCROLL_DOWN, 8'hFF);
    queue_req(CMD_NONE, 8'h5A);
    write_reg(tcw_pkg::REG_HIGHLIGHT_MODE, 1);
    queue_req(tcw_pkg::CMD_CHAR, 8'h80);
    queue_req(tcw_pkg::CMD_CHAR, 8'h7F);
    wait_drained();
    // region ends right after the cursor
    write_reg(tcw_pkg::REG_REGION_SIZE, con_cursor + 1 - reg_base);
    queue_req(tcw_pkg::CMD_CHAR, 8'h41);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    write_reg(tcw_pkg::REG_HIGHLIGHT_MODE, 0);
    write_reg(tcw_pkg::REG_REGION_BASE, 0);
    write_reg(tcw_pkg::REG_REGION_SIZE, 16384);
    repeat (3) queue_req(tcw_pkg::CMD_SCROLL_DOWN, 8'h00);
    wait_drained();
    // scroll up clamps at a base that is not a whole row away
    write_reg(tcw_pkg::REG_REGION_BASE, con_view >= 30 ? con_view - 30 : 0);
    repeat (2) queue_req(tcw_pkg::CMD_SCROLL_UP, 8'h00);

    for (int chunk = 0; chunk < 10; chunk++) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: new_base = con_cursor > 300 ? con_cursor - $urandom_range(0, 300) : 0;
        6, 7:             new_base = con_cursor + $urandom_range(1, 200);
        default:          new_base = 0;
      endcase
      if (new_base > tcw_pkg::ADDR_MAX) new_base = tcw_pkg::ADDR_MAX;
      case ($urandom_range(0, 7))
        0:       new_size = 0;
        1:       new_size = 16384;
        2:       new_size = $urandom_range(0, 32767);
        default: new_size = $urandom_range(100, 4000);
      endcase
      write_reg(tcw_pkg::REG_REGION_BASE, new_base | ($urandom_range(0, 1) << 14));
      write_reg(tcw_pkg::REG_REGION_SIZE, new_size);
      write_reg(tcw_pkg::REG_HIGHLIGHT_MODE, $urandom_range(0, 32767));
      write_reg(tcw_pkg::REG_NORMAL_ATTR, $urandom_range(0, 32767));
      write_reg(tcw_pkg::REG_HIGHLIGHT_ATTR, $urandom_range(0, 32767));
      if (chunk == 3 || chunk == 7) hold_requests++;
      chunk_start = sent_total;
      while (sent_total - chunk_start < CHUNK_ITEMS) queue_typing();
    end

    // top of the address space: snap up to a high base, type until the cursor reaches the last cell
    write_reg(tcw_pkg::REG_NORMAL_ATTR, 8'hFF);
    write_reg(tcw_pkg::REG_HIGHLIGHT_ATTR, 8'h00);
    write_reg(tcw_pkg::REG_REGION_SIZE, 16384);
    write_reg(tcw_pkg::REG_REGION_BASE, 16376);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    repeat (10) queue_req(tcw_pkg::CMD_CHAR, 8'($urandom_range(32, 126)));
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    repeat (2) queue_req(tcw_pkg::CMD_SCROLL_DOWN, 8'h00);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    write_reg(tcw_pkg::REG_HIGHLIGHT_MODE, 1);
    write_reg(tcw_pkg::REG_REGION_BASE, tcw_pkg::ADDR_MAX);
    write_reg(tcw_pkg::REG_REGION_SIZE, 32767);
    queue_req(tcw_pkg::CMD_CHAR, 8'h55);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_NEWLINE);
    queue_req(tcw_pkg::CMD_CHAR, tcw_pkg::CH_BACKSPACE);
    queue_req(tcw_pkg::CMD_SCROLL_UP, 8'h00);
    queue_req(tcw_pkg::CMD_SCROLL_DOWN, 8'h00);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tcw_pkg.sv
sv/tcw_stack.sv
sv/tcw_colrem.sv
sv/text_console_writer_unit.sv
dv/tb_top.sv
